/* hdl/lagged_fibonacci_range_rng_defines.svh */
// Assertion macros shared by the lagged Fibonacci range generator.
// Expects signals named clk and rst in the scope of each use.
`ifndef LAGGED_FIBONACCI_RANGE_RNG_DEFINES_SVH
`define LAGGED_FIBONACCI_RANGE_RNG_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define LFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define LFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lfr_pkg.sv */
// Shared types, constants and helpers for the lagged Fibonacci range generator.
// No dependencies.
package lfr_pkg;

  localparam int TableLen      = 55;
  localparam int ShortLagStart = 31;
  localparam int LongLag       = 24;
  localparam int WordW         = 30;
  localparam int AddrW         = 6;
  localparam int OutW          = 24;
  localparam int DropBits      = WordW - OutW;

  typedef logic [WordW-1:0] word_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [OutW-1:0]  out_t;

  // Write port of the lag table
  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } tbl_wr_t;

  // Advance a table index, wrapping from the last entry to the first
  function automatic addr_t ptr_inc(input addr_t p);
    addr_t r;
    if (p == addr_t'(TableLen - 1)) r = '0;
    else                            r = p + addr_t'(1);
    return r;
  endfunction

  // Smear the highest set bit downwards: mask of the next power of two
  function automatic out_t bit_smear(input out_t v);
    out_t r;
    r = v;
    for (int s = 1; s < OutW; s = s * 2) begin
      r = r | (r >> s);
    end
    return r;
  endfunction

endpackage

/* hdl/lagged_fibonacci_range_rng.sv */
// Lagged Fibonacci (55/24) range generator: top level with control sequencer.
// Depends on lfr_pkg, lfr_table and lagged_fibonacci_range_rng_defines.svh.
//
// A word is taken when start is high and busy is low. A reseed word (mode 1)
// rewrites the whole table, one entry a cycle, and keeps busy high until all
// 55 entries are written; it gives no result. A draw word (mode 0) first
// works out the span in the setup state; an empty or single span then returns
// range_from at once. Otherwise each generator step is the table's registered
// read (READ state) followed by the add and write-back (CALC state), and steps
// repeat until one lands inside the span: under two steps on average. The
// result strobe rises with the kept step's write-back, and busy falls with it,
// so the next word can be taken at the edge that ends the strobe. The result
// is marked by valid for exactly one cycle and cannot be held off.
// After reset the block fills the table with seed zero and is busy meanwhile.
module lagged_fibonacci_range_rng (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                mode,
  input  logic [29:0]         seed,
  input  logic signed [23:0]  range_from,
  input  logic signed [23:0]  range_to,
  output logic                valid,
  output logic signed [23:0]  value
);
  import lfr_pkg::*;

  `include "lagged_fibonacci_range_rng_defines.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CALC  = 3'd4;

  logic [2:0] state;
  addr_t      wp;
  addr_t      lp;
  addr_t      idx;
  word_t      seed_q;
  word_t      prev1;
  word_t      prev2;
  out_t       from_q;
  out_t       to_q;
  out_t       span_m1;
  out_t       mask;

  tbl_wr_t    wr;
  word_t      rd_a;
  word_t      rd_b;
  word_t      fill_data;
  word_t      sum;
  out_t       number;
  logic       hit;
  logic [OutW:0] diff;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  lfr_table u_table (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (wp),
    .rd_addr_b (lp),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // Fibonacci fill word for the current index
  always_comb begin
    if (idx == addr_t'(0))      fill_data = seed_q;
    else if (idx == addr_t'(1)) fill_data = word_t'(1);
    else                        fill_data = prev1 + prev2;
  end

  // Generator step: lagged sum, masked draw and range check
  assign sum    = rd_a + rd_b;
  assign number = sum[WordW-1:DropBits] & mask;
  assign hit    = (number <= span_m1);
  assign diff   = {to_q[OutW-1], to_q} - {from_q[OutW-1], from_q};

  // Table write port: fill sweep or step write-back
  always_comb begin
    wr = '0;
    if (state == S_FILL) begin
      wr.en   = 1'b1;
      wr.addr = idx;
      wr.data = fill_data;
    end else if (state == S_CALC) begin
      wr.en   = 1'b1;
      wr.addr = wp;
      wr.data = sum;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_FILL;
      idx    <= '0;
      seed_q <= '0;
      wp     <= '0;
      lp     <= addr_t'(ShortLagStart);
      valid  <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (mode) begin
              seed_q <= seed;
              idx    <= '0;
              wp     <= '0;
              lp     <= addr_t'(ShortLagStart);
              state  <= S_FILL;
            end else begin
              from_q <= range_from;
              to_q   <= range_to;
              state  <= S_SETUP;
            end
          end
        end
        S_FILL: begin
          prev2 <= prev1;
          prev1 <= fill_data;
          if (idx == addr_t'(TableLen - 1)) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + addr_t'(1);
          end
        end
        S_SETUP: begin
          // empty or single span: answer with the lower end, no step
          if (diff[OutW] || (diff == '0)) begin
            value <= from_q;
            valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            span_m1 <= diff[OutW-1:0];
            mask    <= bit_smear(diff[OutW-1:0]);
            state   <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CALC;
        end
        S_CALC: begin
          wp <= ptr_inc(wp);
          lp <= ptr_inc(lp);
          if (hit) begin
            value <= from_q + number;
            valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Pointers keep their fixed distance of 31 entries
  `LFR_ASSERT_NOW(a_ptr_gap, 1'b1, (wp < addr_t'(LongLag)) ? (lp == wp + addr_t'(ShortLagStart)) : (lp == wp - addr_t'(LongLag)), "lag pointers out of step")
  // A result strobe lasts one cycle
  `LFR_ASSERT_NEXT(a_valid_pulse, valid, !valid, "result strobe longer than one cycle")
  // Every accepted word occupies the block
  `LFR_ASSERT_NEXT(a_accept_busy, accept, busy, "block not busy after taking a word")
  // A kept draw lies inside the span
  `LFR_ASSERT_NOW(a_draw_in_span, (state == S_CALC) && hit, number <= span_m1 && number <= mask, "draw outside span")

endmodule

/* hdl/lfr_table.sv */
// Lag table: 55 words of 30 bits, one write port and two registered read ports.
// Depends on lfr_pkg.
module lfr_table (
  input  logic            clk,
  input  lfr_pkg::tbl_wr_t wr,
  input  lfr_pkg::addr_t  rd_addr_a,
  input  lfr_pkg::addr_t  rd_addr_b,
  output lfr_pkg::word_t  rd_data_a,
  output lfr_pkg::word_t  rd_data_b
);
  import lfr_pkg::*;

  word_t mem [TableLen];

  // Write one word
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read two words, registered
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
